### src/frrg_pkg.sv
package frrg_pkg;

  typedef struct packed {
    logic        enable;
    logic [15:0] measured_rate;
    logic [15:0] native_rate;
    logic [3:0]  cur_scale;
  } in_item_t;

  typedef struct packed {
    logic       scale_write;
    logic [3:0] set_scale;
    logic [1:0] bottleneck;
    logic       probing;
  } out_item_t;

  // effective settings after the limits are applied
  typedef struct packed {
    logic [3:0] min_scale;
    logic [3:0] max_scale;
    logic [9:0] cooldown;
    logic [5:0] hyst;
  } cfg_t;

  // what the front learns about an item from its rates alone
  typedef struct packed {
    logic       below;
    logic       above;
    logic [1:0] down_steps;
    logic [1:0] up_steps;
  } class_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_GRADE,
    BK_APPLY
  } back_state_t;

  localparam int ITEM_W   = $bits(in_item_t);
  localparam int CLASS_W  = $bits(class_t);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HYST      = 2'd3;

  localparam logic [3:0] RST_MIN_SCALE = 4'd1;
  localparam logic [3:0] RST_MAX_SCALE = 4'd4;
  localparam logic [9:0] RST_COOLDOWN  = 10'd60;
  localparam logic [5:0] RST_HYST      = 6'd5;
  localparam logic [5:0] HYST_MAX      = 6'd50;

  localparam logic [1:0] BC_UNKNOWN = 2'd0;
  localparam logic [1:0] BC_GPU     = 2'd1;
  localparam logic [1:0] BC_CPU     = 2'd2;

  localparam int RATE_FALLBACK = 60;
  localparam int RATE_LOW      = 20;
  localparam int RATE_HIGH     = 240;
  localparam int PCT_SCALE     = 100;
  localparam int GAIN_DIV      = 50;

  function automatic int target_width(input int frac_bits);
    return $clog2((RATE_HIGH << frac_bits) + 1);
  endfunction

endpackage

### src/frame_rate_resolution_governor_core.sv
// Per-frame resolution governor. Push one item per presented frame; one
// result item comes back for each. The front takes an item every clock
// while full is low, through its two pipeline stages into a two-entry queue;
// with the back busy and the result port held, up to six items are in flight
// (two in the front, two in the queue, one in the back, one on the result
// port) before full rises. The back handles one item at a time through load,
// probe grading and apply and loads the next only once the last is applied;
// a result waits on the result port while the back keeps working on the next
// item. Rates are unsigned fixed point with RATE_FRAC_BITS fraction bits.
// Configuration writes are meant to happen only while no item is in flight.
module frame_rate_resolution_governor_core #(
  parameter int RATE_FRAC_BITS = 6
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  frrg_pkg::in_item_t                    item,
  output logic                                  empty,
  input  logic                                  pop,
  output frrg_pkg::out_item_t                   result,
  input  logic                                  cfg_write,
  input  logic [frrg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [frrg_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import frrg_pkg::*;

  localparam int TW = target_width(RATE_FRAC_BITS);
  localparam int QW = ITEM_W + CLASS_W + TW;

  logic [3:0]    min_scale;
  logic [3:0]    max_scale;
  logic [9:0]    cooldown_frames;
  logic [5:0]    hysteresis_pct;
  cfg_t          eff;

  logic          q_full;
  logic          q_push;
  logic          q_empty;
  logic          q_pop;
  in_item_t      f_item;
  class_t        f_cls;
  logic [TW-1:0] f_target;
  in_item_t      b_item;
  class_t        b_cls;
  logic [TW-1:0] b_target;
  logic [QW-1:0] q_din;
  logic [QW-1:0] q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_scale       <= RST_MIN_SCALE;
      max_scale       <= RST_MAX_SCALE;
      cooldown_frames <= RST_COOLDOWN;
      hysteresis_pct  <= RST_HYST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_SCALE: min_scale       <= cfg_data[3:0];
        REG_MAX_SCALE: max_scale       <= cfg_data[3:0];
        REG_COOLDOWN:  cooldown_frames <= cfg_data[9:0];
        REG_HYST:      hysteresis_pct  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff.min_scale = (min_scale == '0) ? 4'd1 : min_scale;
    eff.max_scale = (max_scale < eff.min_scale) ? eff.min_scale : max_scale;
    eff.cooldown  = (cooldown_frames == '0) ? 10'd1 : cooldown_frames;
    eff.hyst      = (hysteresis_pct > HYST_MAX) ? HYST_MAX : hysteresis_pct;
  end

  frrg_front #(
    .RATE_FRAC_BITS(RATE_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cfg      (eff),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (f_item),
    .q_cls    (f_cls),
    .q_target (f_target)
  );

  assign q_din = {f_item, f_cls, f_target};

  frrg_queue #(
    .W     (QW),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .din   (q_din),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_dout)
  );

  assign {b_item, b_cls, b_target} = q_dout;

  frrg_back #(
    .RATE_FRAC_BITS(RATE_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (eff),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_item   (b_item),
    .q_cls    (b_cls),
    .q_target (b_target),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

### src/frrg_queue.sv
module frrg_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign dout    = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (wptr == rptr) |-> (count == '0 || count == CW'(DEPTH)))
    else $error("queue pointers disagree with count");

endmodule

### src/frrg_front.sv
module frrg_front #(
  parameter int RATE_FRAC_BITS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  frrg_pkg::in_item_t  item,
  input  frrg_pkg::cfg_t      cfg,
  input  logic                q_full,
  output logic                q_push,
  output frrg_pkg::in_item_t  q_item,
  output frrg_pkg::class_t    q_cls,
  output logic [frrg_pkg::target_width(RATE_FRAC_BITS)-1:0] q_target
);

  import frrg_pkg::*;

  localparam int TW    = target_width(RATE_FRAC_BITS);
  localparam int NW    = (TW > 16) ? TW : 16;
  localparam int PW    = (TW + 8 > 23) ? TW + 8 : 23;
  localparam int DW    = PW + 3;
  localparam int ONE_I = 1 << RATE_FRAC_BITS;

  localparam logic [NW-1:0] RATE_ONE = NW'(ONE_I);
  localparam logic [NW-1:0] RATE_FB  = NW'(RATE_FALLBACK * ONE_I);
  localparam logic [NW-1:0] RATE_MIN = NW'(RATE_LOW * ONE_I);
  localparam logic [NW-1:0] RATE_MAX = NW'(RATE_HIGH * ONE_I);

  logic          adv;
  logic [NW-1:0] nat_w;
  logic [NW-1:0] tgt_w;

  logic          s1_valid;
  in_item_t      s1_item;
  logic [TW-1:0] s1_target;

  logic          s2_valid;
  in_item_t      s2_item;
  logic [TW-1:0] s2_target;
  logic [PW-1:0] s2_lowm;
  logic [PW-1:0] s2_highm;
  logic [PW-1:0] s2_v100;
  logic [PW-1:0] s2_t100;

  logic [PW-1:0] excess;
  logic [DW-1:0] excess2;
  logic [DW-1:0] excess6;
  logic [DW-1:0] t100x;
  logic [DW-1:0] t500;
  class_t        cls;

  // the whole pipe stalls while its last item waits on the queue
  assign adv  = !s2_valid || !q_full;
  assign full = !adv;

  always_comb begin
    nat_w = NW'(item.native_rate);
    tgt_w = (nat_w <= RATE_ONE) ? RATE_FB : nat_w;
    if (tgt_w < RATE_MIN) begin
      tgt_w = RATE_MIN;
    end else if (tgt_w > RATE_MAX) begin
      tgt_w = RATE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= push;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item   <= item;
      s1_target <= TW'(tgt_w);
      s2_item   <= s1_item;
      s2_target <= s1_target;
      s2_lowm   <= PW'(s1_target) * PW'(7'(PCT_SCALE) - 7'(cfg.hyst));
      s2_highm  <= PW'(s1_target) * PW'(8'(PCT_SCALE) + 8'(cfg.hyst));
      s2_v100   <= PW'(s1_item.measured_rate) * PW'(PCT_SCALE);
      s2_t100   <= PW'(s1_target) * PW'(PCT_SCALE);
    end
  end

  // rounded step count 3*excess/target is at least 2 when 2*excess >= 100*target,
  // at least 3 when 6*excess >= 500*target
  always_comb begin
    cls.below = s2_v100 < s2_lowm;
    cls.above = s2_v100 > s2_highm;
    excess    = cls.below ? s2_lowm - s2_v100 : s2_v100 - s2_highm;
    excess2   = DW'(excess) << 1;
    excess6   = (DW'(excess) << 2) + (DW'(excess) << 1);
    t100x     = DW'(s2_t100);
    t500      = (t100x << 2) + t100x;
    if (excess6 >= t500) begin
      cls.down_steps = 2'd3;
    end else if (excess2 >= t100x) begin
      cls.down_steps = 2'd2;
    end else begin
      cls.down_steps = 2'd1;
    end
    cls.up_steps = (excess2 >= t100x) ? 2'd2 : 2'd1;
  end

  assign q_push   = s2_valid && !q_full;
  assign q_item   = s2_item;
  assign q_cls    = cls;
  assign q_target = s2_target;

endmodule

### src/frrg_back.sv
module frrg_back #(
  parameter int RATE_FRAC_BITS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  frrg_pkg::cfg_t      cfg,
  input  logic                q_empty,
  output logic                q_pop,
  input  frrg_pkg::in_item_t  q_item,
  input  frrg_pkg::class_t    q_cls,
  input  logic [frrg_pkg::target_width(RATE_FRAC_BITS)-1:0] q_target,
  output logic                empty,
  input  logic                pop,
  output frrg_pkg::out_item_t result
);

  import frrg_pkg::*;

  localparam int TW    = target_width(RATE_FRAC_BITS);
  localparam int GW    = (TW > 22) ? TW : 22;
  localparam int ONE_I = 1 << RATE_FRAC_BITS;
  localparam logic [15:0] HALF_ONE = 16'(ONE_I >> 1);
  localparam logic [15:0] FW_MAX   = 16'hFFFF;

  back_state_t   state;
  back_state_t   state_next;
  logic          load;
  logic          grade;
  logic          commit;

  in_item_t      w_item;
  class_t        w_cls;
  logic [TW-1:0] w_target;
  logic          w_gpu;

  logic          active;
  logic          active_next;
  logic          probe_open;
  logic          probe_open_next;
  logic [15:0]   frames_waited;
  logic [15:0]   frames_waited_next;
  logic [3:0]    saved_scale;
  logic [3:0]    saved_scale_next;
  logic [15:0]   saved_rate;
  logic [15:0]   saved_rate_next;
  logic [1:0]    bound_class;
  logic [1:0]    bound_class_next;

  logic          out_valid;
  out_item_t     out_data;
  out_item_t     res;

  logic [15:0]   gain;
  logic [GW-1:0] gain50;
  logic          gpu_now;

  logic [3:0]    cur;
  logic [3:0]    mn;
  logic [3:0]    mx;
  logic [15:0]   fw;
  logic [15:0]   fw_bump;
  logic [4:0]    lo_plus;
  logic [4:0]    hi_sum;
  logic [3:0]    n_scale;
  logic [1:0]    bc;
  logic          stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    grade      = 1'b0;
    commit     = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          load       = 1'b1;
          state_next = BK_GRADE;
        end
      end
      BK_GRADE: begin
        grade      = 1'b1;
        state_next = BK_APPLY;
      end
      BK_APPLY: begin
        if (!out_valid || pop) begin
          commit     = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign q_pop = load;

  // probe grading: the step down paid off when the rate rose by half a frame
  // and by at least 2% of target
  assign gain    = w_item.measured_rate - saved_rate;
  assign gain50  = GW'(gain) * GW'(GAIN_DIV);
  assign gpu_now = (w_item.measured_rate > saved_rate) && (gain >= HALF_ONE) &&
                   (gain50 >= GW'(w_target));

  always_ff @(posedge clk) begin
    if (load) begin
      w_item   <= q_item;
      w_cls    <= q_cls;
      w_target <= q_target;
    end
    if (grade) begin
      w_gpu <= gpu_now;
    end
  end

  assign cur = w_item.cur_scale;
  assign mn  = cfg.min_scale;
  assign mx  = cfg.max_scale;

  always_comb begin
    active_next        = active;
    probe_open_next    = probe_open;
    frames_waited_next = frames_waited;
    saved_scale_next   = saved_scale;
    saved_rate_next    = saved_rate;
    bound_class_next   = bound_class;
    res                = '0;
    fw                 = active ? frames_waited : '0;
    fw_bump            = (fw == FW_MAX) ? fw : fw + 16'd1;
    lo_plus            = 5'(mn) + 5'(w_cls.down_steps);
    hi_sum             = 5'(cur) + 5'(w_cls.up_steps);
    n_scale            = '0;
    stop               = 1'b0;
    bc                 = bound_class;
    if (!w_item.enable) begin
      active_next = 1'b0;
    end else begin
      active_next = 1'b1;
      if (!active) begin
        frames_waited_next = '0;
        probe_open_next    = 1'b0;
      end
      if (fw < 16'(cfg.cooldown)) begin
        frames_waited_next = fw_bump;
      end else if (w_item.measured_rate != '0) begin
        if (active && probe_open) begin
          probe_open_next = 1'b0;
          if (w_gpu) begin
            bc               = BC_GPU;
            bound_class_next = BC_GPU;
          end else begin
            // cpu bound: undo the probe step
            bound_class_next   = BC_CPU;
            stop               = 1'b1;
            frames_waited_next = '0;
            if (cur != saved_scale && saved_scale >= mn && saved_scale <= mx) begin
              res.scale_write = 1'b1;
              res.set_scale   = saved_scale;
            end
          end
        end
        if (!stop) begin
          if (w_cls.below) begin
            if (cur > mn) begin
              if (bc == BC_UNKNOWN) begin
                saved_scale_next   = cur;
                saved_rate_next    = w_item.measured_rate;
                res.scale_write    = 1'b1;
                res.set_scale      = cur - 4'd1;
                probe_open_next    = 1'b1;
                frames_waited_next = '0;
              end else if (bc == BC_CPU) begin
                bound_class_next   = BC_UNKNOWN;
                frames_waited_next = '0;
              end else begin
                n_scale = (5'(cur) > lo_plus) ? cur - 4'(w_cls.down_steps) : mn;
                if (n_scale != cur) begin
                  res.scale_write    = 1'b1;
                  res.set_scale      = n_scale;
                  frames_waited_next = '0;
                end else begin
                  frames_waited_next = fw_bump;
                end
              end
            end else begin
              // already at the floor
              bound_class_next   = BC_CPU;
              frames_waited_next = fw_bump;
            end
          end else if (w_cls.above && cur < mx) begin
            n_scale = (hi_sum > 5'(mx)) ? mx : 4'(hi_sum);
            if (n_scale != cur) begin
              res.scale_write    = 1'b1;
              res.set_scale      = n_scale;
              frames_waited_next = '0;
            end else begin
              frames_waited_next = fw_bump;
            end
          end else begin
            frames_waited_next = fw_bump;
          end
        end
      end
    end
    res.bottleneck = bound_class_next;
    res.probing    = probe_open_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      probe_open    <= 1'b0;
      frames_waited <= '0;
      saved_scale   <= '0;
      saved_rate    <= '0;
      bound_class   <= BC_UNKNOWN;
      out_valid     <= 1'b0;
    end else begin
      if (commit) begin
        active        <= active_next;
        probe_open    <= probe_open_next;
        frames_waited <= frames_waited_next;
        saved_scale   <= saved_scale_next;
        saved_rate    <= saved_rate_next;
        bound_class   <= bound_class_next;
        out_valid     <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data <= res;
    end
  end

  assign empty  = !out_valid;
  assign result = out_data;

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.scale_write) |-> (out_data.set_scale == '0))
    else $error("new scale set without a write");
  a_probe_unknown: assert property (@(posedge clk) disable iff (rst)
    probe_open |-> (bound_class == BC_UNKNOWN))
    else $error("probe open with a known bottleneck");
  a_write_restarts: assert property (@(posedge clk) disable iff (rst)
    (commit && res.scale_write) |=> (frames_waited == '0))
    else $error("cooldown not restarted after a scale change");

endmodule
